// ===== hdl/d2h_pkg.sv =====
package d2h_pkg;

   localparam int MANT_BITS       = 10;
   localparam int INT_BITS        = 16;
   localparam int FVAL_BITS       = 30;
   localparam int FDIG_BITS       = 4;
   localparam int EXP_BITS        = 5;
   localparam int MAX_FRAC_DIGITS = 9;
   localparam int EXP_BIAS        = 15;
   localparam int BELOW_BITS      = $clog2(INT_BITS);
   localparam int CNT_BITS        = $clog2(MANT_BITS + 1);

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_INT_ZERO = 2'd1,
      STATUS_FRAC_BIG = 2'd2
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic setup;
      logic step;
      logic publish;
   } d2h_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic steps_done;
      logic rsp_busy;
   } d2h_stat_type;

   // denominator for a given digit count, count already clamped
   function automatic logic [FVAL_BITS-1:0] pow_ten(input logic [FDIG_BITS-1:0] digits);
      logic [FVAL_BITS-1:0] p;
      case (digits)
         4'd0:    p = 30'd1;
         4'd1:    p = 30'd10;
         4'd2:    p = 30'd100;
         4'd3:    p = 30'd1000;
         4'd4:    p = 30'd10000;
         4'd5:    p = 30'd100000;
         4'd6:    p = 30'd1000000;
         4'd7:    p = 30'd10000000;
         4'd8:    p = 30'd100000000;
         default: p = 30'd1000000000;
      endcase
      return p;
   endfunction

endpackage

// ===== hdl/d2h_if.sv =====
interface d2h_req_if import d2h_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 negative;
   logic [INT_BITS-1:0]  integer_part;
   logic [FVAL_BITS-1:0] fraction_value;
   logic [FDIG_BITS-1:0] fraction_digits;

   modport source (output valid, negative, integer_part, fraction_value, fraction_digits,
                   input ready);
   modport sink   (input valid, negative, integer_part, fraction_value, fraction_digits,
                   output ready);
endinterface

interface d2h_rsp_if import d2h_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 sign;
   logic [EXP_BITS-1:0]  exponent;
   logic [MANT_BITS-1:0] mantissa;
   logic [1:0]           status;

   modport source (output valid, sign, exponent, mantissa, status, input ready);
   modport sink   (input valid, sign, exponent, mantissa, status, output ready);
endinterface

// ===== hdl/d2h_ctrl.sv =====
module d2h_ctrl import d2h_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  d2h_stat_type stat,
   output d2h_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_ITER
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;

   always_comb begin
      cmd.load    = (state_ff == ST_IDLE) && req_valid && req_ready_ff;
      cmd.setup   = (state_ff == ST_SETUP);
      cmd.step    = (state_ff == ST_ITER) && !stat.steps_done;
      cmd.publish = (state_ff == ST_ITER) && stat.steps_done && !stat.rsp_busy;
   end

   assign req_ready = req_ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_ready_ff) begin
                  state_ff     <= ST_SETUP;
                  req_ready_ff <= 1'b0;
               end
            end
            ST_SETUP: begin
               state_ff <= ST_ITER;
            end
            ST_ITER: begin
               // hold the finished word until the output register frees up
               if (stat.steps_done && !stat.rsp_busy) begin
                  state_ff     <= ST_IDLE;
                  req_ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff     <= ST_IDLE;
               req_ready_ff <= 1'b1;
            end
         endcase
      end
   end

endmodule

// ===== hdl/d2h_dp.sv =====
module d2h_dp import d2h_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_negative,
   input  logic [INT_BITS-1:0]  req_integer_part,
   input  logic [FVAL_BITS-1:0] req_fraction_value,
   input  logic [FDIG_BITS-1:0] req_fraction_digits,
   input  d2h_cmd_type          cmd,
   output d2h_stat_type         stat,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_sign,
   output logic [EXP_BITS-1:0]  rsp_exponent,
   output logic [MANT_BITS-1:0] rsp_mantissa,
   output status_type           rsp_status
);

   logic                  neg_ff;
   logic [INT_BITS-1:0]   ipart_ff;
   logic [FVAL_BITS-1:0]  fval_ff;
   logic [FVAL_BITS-1:0]  denom_ff;
   logic [FVAL_BITS-1:0]  rem_ff;
   logic                  frac_ok_ff;
   logic [MANT_BITS-1:0]  mant_ff;
   logic [CNT_BITS-1:0]   cnt_ff;
   logic [EXP_BITS-1:0]   exp_ff;
   status_type            status_ff;

   logic                  rsp_valid_ff;
   logic                  rsp_sign_ff;
   logic [EXP_BITS-1:0]   rsp_exp_ff;
   logic [MANT_BITS-1:0]  rsp_mant_ff;
   status_type            rsp_status_ff;

   logic [FDIG_BITS-1:0]  digits_clamp;
   logic [BELOW_BITS-1:0] below;
   logic [INT_BITS-1:0]   low_bits;
   logic [INT_BITS-1:0]   low_shift;
   logic                  frac_ok;
   logic [MANT_BITS-1:0]  mant_in;
   logic [CNT_BITS-1:0]   cnt_in;
   logic [EXP_BITS-1:0]   exp_in;
   status_type            status_in;
   logic [FVAL_BITS:0]    rem_dbl;
   logic                  take;
   logic [FVAL_BITS-1:0]  rem_in;

   assign digits_clamp = (req_fraction_digits > FDIG_BITS'(MAX_FRAC_DIGITS)) ?
                         FDIG_BITS'(MAX_FRAC_DIGITS) : req_fraction_digits;

   // leading-one position of the integer part
   always_comb begin
      below = '0;
      for (int i = 0; i < INT_BITS; i++) begin
         if (ipart_ff[i]) begin
            below = BELOW_BITS'(i);
         end
      end
   end

   // integer bits below the leading one
   always_comb begin
      for (int i = 0; i < INT_BITS; i++) begin
         low_bits[i] = ipart_ff[i] && (BELOW_BITS'(i) < below);
      end
   end

   assign low_shift = low_bits >> (below - BELOW_BITS'(MANT_BITS));
   assign frac_ok   = fval_ff < denom_ff;

   always_comb begin
      if (ipart_ff == '0) begin
         mant_in   = '0;
         cnt_in    = '0;
         exp_in    = '0;
         status_in = STATUS_INT_ZERO;
      end else begin
         exp_in    = EXP_BITS'(EXP_BIAS) + EXP_BITS'(below);
         status_in = frac_ok ? STATUS_OK : STATUS_FRAC_BIG;
         if (below <= BELOW_BITS'(MANT_BITS)) begin
            mant_in = low_bits[MANT_BITS-1:0];
            cnt_in  = CNT_BITS'(MANT_BITS) - CNT_BITS'(below);
         end else begin
            mant_in = low_shift[MANT_BITS-1:0];
            cnt_in  = '0;
         end
      end
   end

   // one restoring step: double the remainder, subtract the denominator if it fits
   assign rem_dbl = {rem_ff, 1'b0};
   assign take    = frac_ok_ff && (rem_dbl >= {1'b0, denom_ff});
   assign rem_in  = take ? FVAL_BITS'(rem_dbl - {1'b0, denom_ff}) : rem_dbl[FVAL_BITS-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         neg_ff   <= req_negative;
         ipart_ff <= req_integer_part;
         fval_ff  <= req_fraction_value;
         denom_ff <= pow_ten(digits_clamp);
      end
      if (cmd.setup) begin
         rem_ff     <= fval_ff;
         frac_ok_ff <= frac_ok;
         mant_ff    <= mant_in;
         exp_ff     <= exp_in;
         status_ff  <= status_in;
      end else if (cmd.step) begin
         rem_ff  <= rem_in;
         mant_ff <= {mant_ff[MANT_BITS-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.setup) begin
         cnt_ff <= cnt_in;
      end else if (cmd.step) begin
         cnt_ff <= cnt_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_sign_ff   <= neg_ff;
         rsp_exp_ff    <= exp_ff;
         rsp_mant_ff   <= mant_ff;
         rsp_status_ff <= status_ff;
      end
   end

   assign stat.steps_done = (cnt_ff == '0);
   assign stat.rsp_busy   = rsp_valid_ff && !rsp_ready;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_sign     = rsp_sign_ff;
   assign rsp_exponent = rsp_exp_ff;
   assign rsp_mantissa = rsp_mant_ff;
   assign rsp_status   = rsp_status_ff;

endmodule

// ===== hdl/decimal_to_half_float_core.sv =====
// channel   dir  word
// req_chan  in   negative, integer_part, fraction_value, fraction_digits
// rsp_chan  out  sign, exponent, mantissa, status
//
// One word at a time: accept, a setup step (leading-one search and
// integer bits), then one cycle per fraction bit from the restoring
// divide loop (0 to 10), then the word moves to the output register
// once that register is free. Reset is synchronous; it clears the controller
// and the output valid. A stalled rsp_chan holds the result in the output
// register while the next word is accepted and worked on.
module decimal_to_half_float_core import d2h_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   d2h_req_if.sink   req_chan,
   d2h_rsp_if.source rsp_chan
);

   d2h_cmd_type  cmd;
   d2h_stat_type stat;
   status_type   rsp_status;

   d2h_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   d2h_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .req_negative        (req_chan.negative),
      .req_integer_part    (req_chan.integer_part),
      .req_fraction_value  (req_chan.fraction_value),
      .req_fraction_digits (req_chan.fraction_digits),
      .cmd                 (cmd),
      .stat                (stat),
      .rsp_valid           (rsp_chan.valid),
      .rsp_ready           (rsp_chan.ready),
      .rsp_sign            (rsp_chan.sign),
      .rsp_exponent        (rsp_chan.exponent),
      .rsp_mantissa        (rsp_chan.mantissa),
      .rsp_status          (rsp_status)
   );

   assign rsp_chan.status = rsp_status;

endmodule
